// ===== src/anb_pkg.sv =====
// ----------------------------------------------------------------------------
// anb_pkg
// Shared types and constants of the Annex-B to length-prefixed NAL converter.
// ----------------------------------------------------------------------------
`default_nettype none

package anb_pkg;

  // Output capacity; offsets and lengths saturate here.
  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  localparam int unsigned OFF_W = 21;
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_FRAME_BYTES);
  localparam logic [OFF_W-1:0] LEN_GAP = OFF_W'(4);

  // Command queue between front and back end.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

  // NAL unit types that carry parameter sets.
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_LENGTH  = 3'd1,
    KIND_SPS     = 3'd2,
    KIND_PPS     = 3'd3,
    KIND_DONE    = 3'd4
  } item_kind_e;

  // One classified input byte: released zeros, the byte, unit end, frame end.
  typedef struct packed {
    logic [1:0] zeros;      // held-back zeros released before the byte
    logic       has_byte;
    logic [7:0] data;
    logic       unit_mode;  // 1: NAL data of a converted frame, 0: pass-through
    logic       end_unit;
    logic       done;
    logic       conv;       // converted flag for the frame-done word
  } nal_cmd_t;

  typedef struct packed {
    logic     push;
    nal_cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic     valid;
    nal_cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    item_kind_e       item_kind;
    logic [7:0]       out_byte;
    logic [OFF_W-1:0] out_offset;
    logic [OFF_W-1:0] length_value;
    logic [4:0]       unit_type;
    logic             converted;
    logic             overflow;
    logic             last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/anb_if.sv =====
// ----------------------------------------------------------------------------
// anb_if
// Valid/ready channels of the converter: input bytes and output words.
// ----------------------------------------------------------------------------
`default_nettype none

interface anb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface anb_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 item_kind;
  logic [7:0]                 out_byte;
  logic [anb_pkg::OFF_W-1:0]  out_offset;
  logic [anb_pkg::OFF_W-1:0]  length_value;
  logic [4:0]                 unit_type;
  logic                       converted;
  logic                       overflow;
  logic                       last_of_run;

  modport source (output valid, item_kind, out_byte, out_offset, length_value,
                  unit_type, converted, overflow, last_of_run, input ready);
  modport sink   (input valid, item_kind, out_byte, out_offset, length_value,
                  unit_type, converted, overflow, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/annexb_to_length_prefixed_nal_core.sv =====
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal_core
// H.264 Annex-B byte stream to length-prefixed NAL converter.
// ----------------------------------------------------------------------------
// One frame byte is taken per word on in_i, frame_end on the last byte. A
// frame that opens with a 3- or 4-byte start code is converted: payload NAL
// bytes come out at offsets that leave 4 bytes for each unit's length word,
// which follows as a length word when the unit ends; SPS and PPS bytes come
// out on their own kinds. Other frames pass through unchanged. Every frame
// closes with a frame-done word. A byte is accepted every cycle while the
// 4-entry command queue has room; the emitter writes one output word per
// cycle while the output is not stalled. One byte yields up to six words
// (released zeros, the byte, a length word, the frame-done word), and a
// start code that closes no payload unit takes an emitter step that writes
// no word. Words pass through the command queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_to_length_prefixed_nal_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  anb_in_if.sink     in_i,
  anb_out_if.source  out_o
);

  anb_pkg::cmd_push_t push;
  anb_pkg::cmd_head_t head;
  logic               fifo_full;
  logic               fifo_pop;

  anb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_full_i (fifo_full),
    .push_o      (push)
  );

  anb_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (fifo_pop),
    .full_o (fifo_full),
    .head_o (head)
  );

  anb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (fifo_pop),
    .out_o  (out_o)
  );

  // The emitter only retires a command that is in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> head.valid)
  else $error("command popped from empty queue");

  // A frame-done word always closes its run and carries no byte or offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.item_kind == anb_pkg::KIND_DONE)) |->
      (out_o.last_of_run && (out_o.out_offset == '0) && (out_o.out_byte == 8'h00)))
  else $error("malformed frame-done word");

  // Length and parameter-set words only come from converted frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ((out_o.item_kind == anb_pkg::KIND_LENGTH) ||
                     (out_o.item_kind == anb_pkg::KIND_SPS) ||
                     (out_o.item_kind == anb_pkg::KIND_PPS))) |-> out_o.converted)
  else $error("unit word outside a converted frame");

  // A queued command is never dropped: a full queue that is not popped keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_full && !fifo_pop) |=> head.valid)
  else $error("queue lost its contents");

endmodule

`default_nettype wire

// ===== src/anb_front.sv =====
// ----------------------------------------------------------------------------
// anb_front
// Start-code parser: probes the frame opening, holds back zeros and turns
// each input byte into one command for the back end (or none).
// ----------------------------------------------------------------------------
`default_nettype none

module anb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  anb_in_if.sink              in_i,
  input  logic                fifo_full_i,
  output anb_pkg::cmd_push_t  push_o
);

  typedef enum logic [2:0] {
    PH_PROBE   = 3'b001,
    PH_CONVERT = 3'b010,
    PH_PASS    = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] held_q, held_d;
  logic [1:0] probe_q, probe_d;

  logic       accept;
  logic       last;
  logic       is_zero;
  logic       is_one;
  anb_pkg::cmd_push_t push;

  assign in_i.ready = !fifo_full_i;
  assign accept     = in_i.valid && !fifo_full_i;
  assign last       = in_i.frame_end;
  assign is_zero    = (in_i.data_byte == 8'h00);
  assign is_one     = (in_i.data_byte == 8'h01);

  // Classify the accepted byte
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    probe_d = probe_q;
    push    = '0;
    push.cmd.data = in_i.data_byte;
    if (accept) begin
      case (phase_q)
        PH_CONVERT: begin
          push.cmd.unit_mode = 1'b1;
          push.cmd.conv      = 1'b1;
          push.cmd.done      = last;
          if (is_one && held_q[1]) begin
            // start code: close the running unit
            push.push         = 1'b1;
            push.cmd.end_unit = 1'b1;
            held_d            = 2'd0;
          end else if (is_zero && !last) begin
            if (held_q != 2'd3) begin
              held_d = held_q + 2'd1;
            end else begin
              // oldest zero of a long run is unit data
              push.push         = 1'b1;
              push.cmd.has_byte = 1'b1;
            end
          end else begin
            push.push         = 1'b1;
            push.cmd.zeros    = held_q;
            push.cmd.has_byte = 1'b1;
            push.cmd.end_unit = last;
            held_d            = 2'd0;
          end
        end
        PH_PASS: begin
          push.push         = 1'b1;
          push.cmd.has_byte = 1'b1;
          push.cmd.done     = last;
        end
        default: begin
          if (is_one && probe_q[1]) begin
            phase_d       = PH_CONVERT;
            held_d        = 2'd0;
            push.push     = last;
            push.cmd.done = last;
            push.cmd.conv = 1'b1;
          end else if (is_zero && (probe_q != 2'd3) && !last) begin
            probe_d = probe_q + 2'd1;
          end else begin
            // no start code: replay probed zeros and pass the frame
            phase_d           = PH_PASS;
            push.push         = 1'b1;
            push.cmd.zeros    = probe_q;
            push.cmd.has_byte = 1'b1;
            push.cmd.done     = last;
            probe_d           = 2'd0;
          end
        end
      endcase
      if (last) begin
        phase_d = PH_PROBE;
        held_d  = 2'd0;
        probe_d = 2'd0;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PROBE;
      held_q  <= 2'd0;
      probe_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      probe_q <= probe_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/anb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// anb_cmd_fifo
// Short register queue of commands between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  anb_pkg::cmd_push_t  push_i,
  input  logic                pop_i,
  output logic                full_o,
  output anb_pkg::cmd_head_t  head_o
);

  anb_pkg::nal_cmd_t mem_q [anb_pkg::FIFO_DEPTH];

  logic [anb_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [anb_pkg::FIFO_AW:0]   cnt_q;
  logic                        do_push;
  logic                        do_pop;

  assign full_o       = (cnt_q == (anb_pkg::FIFO_AW+1)'(anb_pkg::FIFO_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  // Pointers wrap on their own, the depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/anb_back.sv =====
// ----------------------------------------------------------------------------
// anb_back
// Emitter: walks each command step by step, keeps the unit and offset state
// and writes one output word per cycle into the output register when free.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  anb_pkg::cmd_head_t  head_i,
  output logic                pop_o,
  anb_out_if.source           out_o
);

  localparam int unsigned W = anb_pkg::OFF_W;

  typedef enum logic [1:0] {
    ACT_ZERO = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_END  = 2'd2,
    ACT_DONE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    UK_PAYLOAD = 2'd0,
    UK_SPS     = 2'd1,
    UK_PPS     = 2'd2
  } unit_kind_e;

  // progress within the head command
  logic [1:0] zc_q, zc_d;
  logic       byte_done_q, byte_done_d;
  logic       end_done_q, end_done_d;

  // unit and frame state
  logic       active_q, active_d;
  unit_kind_e kind_q, kind_d;
  logic [4:0] type_q, type_d;
  logic [W-1:0] len_q, len_d;
  logic [W-1:0] base_q, base_d;
  logic [W-1:0] wo_q, wo_d;
  logic       ovf_q, ovf_d;

  // output register
  logic                out_valid_q;
  anb_pkg::out_item_t  out_q;

  act_e       act;
  logic       final_step;
  logic       emit;
  logic       slot_free;
  logic       fire;
  anb_pkg::out_item_t item;

  logic [7:0]   v;
  logic         starting;
  logic [4:0]   type_n;
  unit_kind_e   kind_n;
  logic         new_payload;
  logic         gap_ovf;
  logic [W-1:0] wo_a;
  logic         slot_ovf;
  logic [W-1:0] pos;
  logic [W-1:0] wo_b;
  logic [W-1:0] len0;
  logic         len_ovf;
  logic [W-1:0] len_n;
  logic         is_payload;

  // Pick the current step of the head command
  always_comb begin
    if (head_i.cmd.zeros != zc_q) begin
      act        = ACT_ZERO;
      final_step = 1'b0;
    end else if (head_i.cmd.has_byte && !byte_done_q) begin
      act        = ACT_BYTE;
      final_step = !head_i.cmd.end_unit && !head_i.cmd.done;
    end else if (head_i.cmd.end_unit && !end_done_q) begin
      act        = ACT_END;
      final_step = !head_i.cmd.done;
    end else begin
      act        = ACT_DONE;
      final_step = 1'b1;
    end
  end

  // Data byte path: unit start, length-word gap, payload slot, unit length
  always_comb begin
    v           = (act == ACT_BYTE) ? head_i.cmd.data : 8'h00;
    starting    = head_i.cmd.unit_mode && !active_q;
    type_n      = starting ? (v[4:0] & anb_pkg::NAL_TYPE_MASK) : type_q;
    if (!starting) begin
      kind_n = kind_q;
    end else if (type_n == anb_pkg::NAL_SPS) begin
      kind_n = UK_SPS;
    end else if (type_n == anb_pkg::NAL_PPS) begin
      kind_n = UK_PPS;
    end else begin
      kind_n = UK_PAYLOAD;
    end
    new_payload = starting && (kind_n == UK_PAYLOAD);
    gap_ovf     = new_payload && (wo_q > (anb_pkg::MAX_OFF - anb_pkg::LEN_GAP));
    if (!new_payload) begin
      wo_a = wo_q;
    end else if (gap_ovf) begin
      wo_a = anb_pkg::MAX_OFF;
    end else begin
      wo_a = wo_q + anb_pkg::LEN_GAP;
    end
    slot_ovf   = (wo_a >= anb_pkg::MAX_OFF);
    pos        = slot_ovf ? anb_pkg::MAX_OFF : wo_a;
    wo_b       = slot_ovf ? anb_pkg::MAX_OFF : (wo_a + W'(1));
    len0       = starting ? '0 : len_q;
    len_ovf    = (len0 >= anb_pkg::MAX_OFF);
    len_n      = len_ovf ? anb_pkg::MAX_OFF : (len0 + W'(1));
    is_payload = !head_i.cmd.unit_mode || (kind_n == UK_PAYLOAD);
  end

  // Build the word and the next state for the current step
  always_comb begin
    item     = '0;
    emit     = 1'b1;
    active_d = active_q;
    kind_d   = kind_q;
    type_d   = type_q;
    len_d    = len_q;
    base_d   = base_q;
    wo_d     = wo_q;
    ovf_d    = ovf_q;
    case (act)
      ACT_ZERO, ACT_BYTE: begin
        item.out_byte  = v;
        item.converted = head_i.cmd.unit_mode;
        item.overflow  = ovf_q | gap_ovf | (is_payload & slot_ovf);
        if (is_payload) begin
          item.item_kind  = anb_pkg::KIND_PAYLOAD;
          item.out_offset = pos;
          wo_d            = wo_b;
        end else begin
          item.item_kind  = (kind_n == UK_SPS) ? anb_pkg::KIND_SPS : anb_pkg::KIND_PPS;
          item.out_offset = len0;
        end
        item.last_of_run = (act == ACT_BYTE) && !head_i.cmd.done &&
                           !(head_i.cmd.end_unit && (kind_n == UK_PAYLOAD));
        ovf_d = item.overflow;
        if (head_i.cmd.unit_mode) begin
          item.unit_type = type_n;
          active_d       = 1'b1;
          kind_d         = kind_n;
          type_d         = type_n;
          len_d          = len_n;
          ovf_d          = item.overflow | len_ovf;
          if (new_payload) begin
            base_d = wo_q;
          end
        end
      end
      ACT_END: begin
        // only payload units get a length word
        emit              = active_q && (kind_q == UK_PAYLOAD);
        item.item_kind    = anb_pkg::KIND_LENGTH;
        item.out_offset   = base_q;
        item.length_value = len_q;
        item.unit_type    = type_q;
        item.converted    = 1'b1;
        item.overflow     = ovf_q;
        item.last_of_run  = !head_i.cmd.done;
        active_d          = 1'b0;
      end
      default: begin
        item.item_kind    = anb_pkg::KIND_DONE;
        item.length_value = wo_q;
        item.converted    = head_i.cmd.conv;
        item.overflow     = ovf_q;
        item.last_of_run  = 1'b1;
        active_d          = 1'b0;
        kind_d            = UK_PAYLOAD;
        type_d            = '0;
        len_d             = '0;
        base_d            = '0;
        wo_d              = '0;
        ovf_d             = 1'b0;
      end
    endcase
  end

  assign slot_free = !out_valid_q || out_o.ready;
  assign fire      = head_i.valid && (!emit || slot_free);
  assign pop_o     = fire && final_step;

  // Step progress
  always_comb begin
    zc_d        = zc_q;
    byte_done_d = byte_done_q;
    end_done_d  = end_done_q;
    if (fire) begin
      if (final_step) begin
        zc_d        = '0;
        byte_done_d = 1'b0;
        end_done_d  = 1'b0;
      end else begin
        case (act)
          ACT_ZERO: zc_d        = zc_q + 2'd1;
          ACT_BYTE: byte_done_d = 1'b1;
          ACT_END:  end_done_d  = 1'b1;
          default:  zc_d        = zc_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_q        <= '0;
      byte_done_q <= 1'b0;
      end_done_q  <= 1'b0;
      active_q    <= 1'b0;
      kind_q      <= UK_PAYLOAD;
      type_q      <= '0;
      len_q       <= '0;
      base_q      <= '0;
      wo_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      zc_q        <= zc_d;
      byte_done_q <= byte_done_d;
      end_done_q  <= end_done_d;
      if (fire) begin
        active_q <= active_d;
        kind_q   <= kind_d;
        type_q   <= type_d;
        len_q    <= len_d;
        base_q   <= base_d;
        wo_q     <= wo_d;
        ovf_q    <= ovf_d;
      end
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= item;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.item_kind    = out_q.item_kind;
  assign out_o.out_byte     = out_q.out_byte;
  assign out_o.out_offset   = out_q.out_offset;
  assign out_o.length_value = out_q.length_value;
  assign out_o.unit_type    = out_q.unit_type;
  assign out_o.converted    = out_q.converted;
  assign out_o.overflow     = out_q.overflow;
  assign out_o.last_of_run  = out_q.last_of_run;

endmodule

`default_nettype wire

// ===== tb/sv/annexb_to_length_prefixed_nal_core_test.sv =====
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal_core_test
// Self-checking bench for the Annex-B to length-prefixed NAL converter.
// ----------------------------------------------------------------------------
// Frame bytes are pushed through the input channel with random gaps, and the
// output channel is stalled at random. Every accepted byte runs through a
// behavioral model of the converter, which queues the words it should cause.
// Each output word is checked field by field against the oldest queued word.
// A short directed set covers the framing corner cases. Random frames follow,
// most of them start-code framed, the rest pass-through and short ones.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_to_length_prefixed_nal_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  // Model of the converter plus the queue of words it predicts.
  class NalScoreboard;
    typedef enum int {PH_PROBE, PH_CONVERT, PH_PASS} phase_e;
    typedef enum int {UNIT_PAYLOAD, UNIT_SPS, UNIT_PPS} unit_e;

    anb_pkg::out_item_t expected_words[$];
    anb_pkg::out_item_t step_words[$];
    int          errors;
    phase_e      phase;
    unit_e       ukind;
    int unsigned held;
    int unsigned probe;
    int unsigned ulen;
    int unsigned ubase;
    int unsigned woff;
    bit          uact;
    bit          ovf;
    logic [4:0]  ctype;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_PROBE;
      ukind = UNIT_PAYLOAD;
      held  = 0;
      probe = 0;
      ulen  = 0;
      ubase = 0;
      woff  = 0;
      uact  = 0;
      ovf   = 0;
      ctype = '0;
    endfunction

    // At most six words per input byte; overflow is taken as it stands now.
    function void put(anb_pkg::item_kind_e k, logic [7:0] b, int unsigned off,
                      int unsigned len, logic [4:0] t, bit conv);
      anb_pkg::out_item_t w;
      if (step_words.size() >= 6) return;
      w.item_kind    = k;
      w.out_byte     = b;
      w.out_offset   = anb_pkg::OFF_W'(off);
      w.length_value = anb_pkg::OFF_W'(len);
      w.unit_type    = t;
      w.converted    = conv;
      w.overflow     = ovf;
      w.last_of_run  = 1'b0;
      step_words = {step_words, w};
    endfunction

    // Next payload position, saturating at capacity.
    function int unsigned claim_slot();
      int unsigned p;
      p = woff;
      if (p >= anb_pkg::MAX_FRAME_BYTES) begin
        ovf  = 1'b1;
        woff = anb_pkg::MAX_FRAME_BYTES;
        return anb_pkg::MAX_FRAME_BYTES;
      end
      woff = p + 1;
      return p;
    endfunction

    function void nal_byte(logic [7:0] b);
      int unsigned pos;
      // First byte opens the unit and decides where it goes
      if (!uact) begin
        uact  = 1'b1;
        ctype = b[4:0] & anb_pkg::NAL_TYPE_MASK;
        ulen  = 0;
        if (ctype == anb_pkg::NAL_SPS) begin
          ukind = UNIT_SPS;
        end else if (ctype == anb_pkg::NAL_PPS) begin
          ukind = UNIT_PPS;
        end else begin
          ukind = UNIT_PAYLOAD;
          ubase = woff;
          if (woff + int'(anb_pkg::LEN_GAP) > anb_pkg::MAX_FRAME_BYTES) begin
            ovf  = 1'b1;
            woff = anb_pkg::MAX_FRAME_BYTES;
          end else begin
            woff += int'(anb_pkg::LEN_GAP);
          end
        end
      end
      if (ukind == UNIT_PAYLOAD) begin
        pos = claim_slot();
        put(anb_pkg::KIND_PAYLOAD, b, pos, 0, ctype, 1'b1);
      end else begin
        pos = (ulen < anb_pkg::MAX_FRAME_BYTES) ? ulen : anb_pkg::MAX_FRAME_BYTES;
        put(ukind == UNIT_SPS ? anb_pkg::KIND_SPS : anb_pkg::KIND_PPS, b, pos, 0, ctype,
            1'b1);
      end
      if (ulen >= anb_pkg::MAX_FRAME_BYTES) begin
        ovf  = 1'b1;
        ulen = anb_pkg::MAX_FRAME_BYTES;
      end else begin
        ulen++;
      end
    endfunction

    // Parameter sets get no length word
    function void close_unit();
      if (uact && ukind == UNIT_PAYLOAD) begin
        put(anb_pkg::KIND_LENGTH, 8'h00, ubase, ulen, ctype, 1'b1);
      end
      uact = 1'b0;
    endfunction

    function void release_zeros();
      while (held > 0) begin
        nal_byte(8'h00);
        held--;
      end
    endfunction

    function void pass_byte(logic [7:0] b);
      put(anb_pkg::KIND_PAYLOAD, b, claim_slot(), 0, 5'd0, 1'b0);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      bit conv;
      step_words.delete();
      case (phase)
        PH_CONVERT: begin
          if (b == 8'h01 && held >= 2) begin
            close_unit();
            held = 0;
          end else if (b == 8'h00 && !last) begin
            if (held < 3) held++;
            else nal_byte(8'h00);
          end else begin
            release_zeros();
            nal_byte(b);
          end
          // Zeros still held at frame end belong to the last unit
          if (last) begin
            release_zeros();
            close_unit();
          end
        end
        PH_PASS: begin
          pass_byte(b);
        end
        default: begin
          if (b == 8'h01 && probe >= 2) begin
            phase = PH_CONVERT;
            held  = 0;
            uact  = 1'b0;
          end else if (b == 8'h00 && probe < 3 && !last) begin
            probe++;
          end else begin
            phase = PH_PASS;
            for (int i = 0; i < probe && i < 3; i++) pass_byte(8'h00);
            probe = 0;
            pass_byte(b);
          end
        end
      endcase
      if (last) begin
        conv = (phase == PH_CONVERT);
        put(anb_pkg::KIND_DONE, 8'h00, 0, woff, 5'd0, conv);
        clear();
      end
      if (step_words.size() > 0) begin
        step_words[step_words.size() - 1].last_of_run = 1'b1;
      end
      expected_words = {expected_words, step_words};
    endfunction

    function bit field_bad(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_word(anb_pkg::out_item_t got);
      anb_pkg::out_item_t want;
      bit                 bad;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual kind %0h offset %0h", $time,
                 got.item_kind, got.out_offset);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      bad  = 1'b0;
      bad |= field_bad("item_kind", 32'(want.item_kind), 32'(got.item_kind));
      bad |= field_bad("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      bad |= field_bad("out_offset", 32'(want.out_offset), 32'(got.out_offset));
      bad |= field_bad("length_value", 32'(want.length_value), 32'(got.length_value));
      bad |= field_bad("unit_type", 32'(want.unit_type), 32'(got.unit_type));
      bad |= field_bad("converted", 32'(want.converted), 32'(got.converted));
      bad |= field_bad("overflow", 32'(want.overflow), 32'(got.overflow));
      bad |= field_bad("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      if (bad) errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   stall_left;
  int   rand_bytes;

  NalScoreboard sb = new();

  anb_in_if  in_if();
  anb_out_if out_if();

  annexb_to_length_prefixed_nal_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_if.ready = 1'b0;
      stall_left   = idle_len();
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    anb_pkg::out_item_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.item_kind    = anb_pkg::item_kind_e'(out_if.item_kind);
      got.out_byte     = out_if.out_byte;
      got.out_offset   = out_if.out_offset;
      got.length_value = out_if.length_value;
      got.unit_type    = out_if.unit_type;
      got.converted    = out_if.converted;
      got.overflow     = out_if.overflow;
      got.last_of_run  = out_if.last_of_run;
      sb.check_word(got);
    end
  end

  // One input word, held until accepted
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.frame_end = last;
    do begin
      @(posedge clk_i);
    end while (in_if.ready !== 1'b1);
    sb.note_byte(b, last);
  endtask

  task automatic send_frame(input byte_q_t f);
    foreach (f[i]) push_byte(f[i], i == f.size() - 1);
  endtask

  // Input goes idle first so the last word is not taken again
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Random frame: mostly start-code framed units, else pass-through or short
  function automatic byte_q_t make_frame();
    byte_q_t    f;
    int         r;
    int         n;
    int         zeros;
    logic [7:0] hdr;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      f = {f, 8'h00};
      f = {f, 8'h00};
      if ($urandom_range(0, 1) != 0) f = {f, 8'h00};
      f = {f, 8'h01};
      n = $urandom_range(0, 4);
      for (int u = 0; u < n; u++) begin
        // separator, sometimes with a longer zero run
        if (u > 0) begin
          r = $urandom_range(0, 9);
          zeros = (r < 5) ? 2 : (r < 8) ? 3 : $urandom_range(4, 6);
          repeat (zeros) f = {f, 8'h00};
          f = {f, 8'h01};
        end
        // some units are left empty
        if ($urandom_range(0, 6) != 0) begin
          hdr = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 4))
            0: hdr[4:0] = anb_pkg::NAL_SPS;
            1: hdr[4:0] = anb_pkg::NAL_PPS;
            2: hdr[4:0] = 5'd5;
            3: hdr[4:0] = 5'd1;
            default: ;
          endcase
          f = {f, hdr};
          repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 9);
            f = {f, (r < 3) ? 8'h00 : (r == 3) ? 8'h01 : 8'($urandom_range(0, 255))};
          end
        end
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) f = {f, 8'h00};
    end else if (r < 85) begin
      repeat ($urandom_range(1, 10)) f = {f, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 9);
        f = {f, (r < 7) ? 8'h00 : (r == 7) ? 8'h01 : 8'($urandom_range(0, 255))};
      end
    end
    return f;
  endfunction

  initial begin
    byte_q_t f;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    stall_left      = 0;
    rand_bytes      = 0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.frame_end = 1'b0;
    out_if.ready    = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 4-byte start code, SPS, PPS, payload with a zero run, trailing zeros
    f = {8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68,
         8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
         8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(f);
    // start codes only, with an empty unit between them
    f = {8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_frame(f);
    // frame that ends while still probing
    f = {8'h00};
    send_frame(f);
    wait_drained();

    // Random frames
    while (rand_bytes < 170) begin
      if ($urandom_range(0, 4) == 0) calm = ~calm;
      f = make_frame();
      send_frame(f);
      rand_bytes += f.size();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/anb_pkg.sv
src/anb_if.sv
src/anb_front.sv
src/anb_cmd_fifo.sv
src/anb_back.sv
src/annexb_to_length_prefixed_nal_core.sv
tb/sv/annexb_to_length_prefixed_nal_core_test.sv
